// ===== design/mlcd_pkg.sv =====
package mlcd_pkg;

  // Panel and store geometry
  localparam int MaxWidth   = 256;
  localparam int MaxHeight  = 256;
  localparam int BplMax     = (MaxWidth + 7) / 8;
  localparam int StoreBytes = BplMax * MaxHeight;
  localparam int AddrW      = $clog2(StoreBytes);
  localparam int BplW       = $clog2(BplMax + 1);
  localparam int DimW       = 9;

  // Register reset values
  localparam logic [8:0] WidthRst     = 9'd144;
  localparam logic [8:0] HeightRst    = 9'd168;
  localparam logic [1:0] RotRst       = 2'd0;
  localparam logic [7:0] ThresholdRst = 8'd168;

  // Panel command bits
  localparam logic [7:0] CmdWrite = 8'h01;
  localparam logic [7:0] CmdVcom  = 8'h02;
  localparam logic [7:0] CmdClear = 8'h04;
  localparam logic [7:0] FillOnes = 8'hFF;
  localparam logic [7:0] FillZero = 8'h00;

  typedef enum logic [1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_ROTATION  = 2'd2,
    REG_THRESHOLD = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    MODE_DRAW       = 3'd0,
    MODE_FILL_WHITE = 3'd1,
    MODE_FILL_BLACK = 3'd2,
    MODE_CLEAR      = 3'd3,
    MODE_REF_START  = 3'd4,
    MODE_REF_LINE   = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    OUT_CLEAR_CMD,
    OUT_WRITE_CMD,
    OUT_ZERO,
    OUT_ADDR,
    OUT_MEM
  } out_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FILL,
    ST_CMD,
    ST_CMD_END,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_LINE_ADDR,
    ST_LINE_RD,
    ST_LINE_DATA,
    ST_LINE_TRAIL,
    ST_LINE_END
  } state_e;

  typedef struct packed {
    logic [8:0] width;
    logic [8:0] height;
    logic [1:0] rotation;
    logic [7:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic     load_item;
    logic     draw_calc;
    logic     draw_rd;
    logic     draw_wr;
    logic     fill_start;
    logic     fill_step;
    logic     line_start;
    logic     line_rd;
    logic     line_next;
    logic     out_load;
    out_sel_e out_sel;
    logic     out_eot;
    logic     out_last;
    logic     vcom_toggle;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  out_free;
    logic  sweep_last;
    logic  byte_last;
    logic  draw_ok;
    logic  line_ok;
    logic  line_final;
  } dp_sts_t;

endpackage

// ===== design/mlcd_regs.sv =====
module mlcd_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output mlcd_pkg::cfg_t     cfg_o
);
  import mlcd_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Update the addressed register on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width     <= WidthRst;
      cfg_q.height    <= HeightRst;
      cfg_q.rotation  <= RotRst;
      cfg_q.threshold <= ThresholdRst;
    end else if (wr_en) begin
      case (idx)
        REG_WIDTH:     cfg_q.width     <= pwdata[8:0];
        REG_HEIGHT:    cfg_q.height    <= pwdata[8:0];
        REG_ROTATION:  cfg_q.rotation  <= pwdata[1:0];
        REG_THRESHOLD: cfg_q.threshold <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Return the raw register value
  always_comb begin
    case (idx)
      REG_WIDTH:     prdata = {23'd0, cfg_q.width};
      REG_HEIGHT:    prdata = {23'd0, cfg_q.height};
      REG_ROTATION:  prdata = {30'd0, cfg_q.rotation};
      REG_THRESHOLD: prdata = {24'd0, cfg_q.threshold};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/mlcd_ctrl.sv =====
module mlcd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mlcd_pkg::dp_sts_t sts_i,
  output mlcd_pkg::dp_cmd_t cmd_o
);
  import mlcd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence one item at a time
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.out_sel = OUT_ZERO;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts_i.mode)
          MODE_DRAW: begin
            cmd_o.draw_calc = 1'b1;
            state_d = ST_DRAW_RD;
          end
          MODE_FILL_WHITE, MODE_FILL_BLACK, MODE_CLEAR: begin
            cmd_o.fill_start = 1'b1;
            state_d = ST_FILL;
          end
          MODE_REF_START: state_d = ST_CMD;
          MODE_REF_LINE: begin
            if (sts_i.line_ok) begin
              cmd_o.line_start = 1'b1;
              state_d = ST_LINE_ADDR;
            end else begin
              state_d = ST_IDLE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = (sts_i.mode == MODE_CLEAR) ? ST_CMD : ST_IDLE;
        end
      end
      ST_CMD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load    = 1'b1;
          cmd_o.vcom_toggle = 1'b1;
          if (sts_i.mode == MODE_CLEAR) begin
            cmd_o.out_sel = OUT_CLEAR_CMD;
            state_d = ST_CMD_END;
          end else begin
            cmd_o.out_sel  = OUT_WRITE_CMD;
            cmd_o.out_last = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_CMD_END: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_eot  = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_DRAW_RD: begin
        if (sts_i.draw_ok) begin
          cmd_o.draw_rd = 1'b1;
          state_d = ST_DRAW_WR;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DRAW_WR: begin
        cmd_o.draw_wr = 1'b1;
        state_d = ST_IDLE;
      end
      ST_LINE_ADDR: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OUT_ADDR;
          cmd_o.line_rd  = 1'b1;
          state_d = ST_LINE_DATA;
        end
      end
      ST_LINE_RD: begin
        cmd_o.line_rd = 1'b1;
        state_d = ST_LINE_DATA;
      end
      ST_LINE_DATA: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OUT_MEM;
          if (sts_i.byte_last) begin
            state_d = ST_LINE_TRAIL;
          end else begin
            cmd_o.line_next = 1'b1;
            state_d = ST_LINE_RD;
          end
        end
      end
      ST_LINE_TRAIL: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = !sts_i.line_final;
          state_d = sts_i.line_final ? ST_LINE_END : ST_IDLE;
        end
      end
      ST_LINE_END: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_eot  = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== design/mlcd_dp.sv =====
module mlcd_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mlcd_pkg::cfg_t    cfg_i,
  input  logic [2:0]        mode_i,
  input  logic [9:0]        pos_x_i,
  input  logic [9:0]        pos_y_i,
  input  logic [15:0]       color_i,
  input  mlcd_pkg::dp_cmd_t cmd_i,
  output mlcd_pkg::dp_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              out_eot_o,
  output logic              out_last_o
);
  import mlcd_pkg::*;

  // Item registers
  mode_e       mode_q;
  logic [9:0]  x_q, y_q;
  logic [5:0]  green_q;

  // Frame store
  logic [7:0]       store_mem [StoreBytes];
  logic [7:0]       rdata_q;
  logic [AddrW-1:0] sweep_q;
  logic [7:0]       fill_val_q;

  // Draw operands
  logic [AddrW-1:0] didx_q;
  logic [2:0]       dbit_q;
  logic             dok_q;
  logic             dset_q;

  // Line walk
  logic [AddrW-1:0] lp_q;
  logic [BplW-1:0]  cnt_q;

  logic             vcom_q;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_eot_q;
  logic             out_last_q;

  logic [BplW-1:0]  bpl;
  logic [DimW-1:0]  eff_w, eff_h;
  logic signed [10:0] xs, ys, ws, hs, px, py;
  logic             clip_ok, rot_ok;
  logic [DimW+BplW-1:0] draw_prod, line_prod;
  logic [AddrW-1:0] draw_idx;
  logic [7:0]       gray;
  logic [1:0]       gray_lo;
  logic [7:0]       vcom_bits;
  logic [7:0]       out_byte_d;
  logic [7:0]       bit_mask;
  logic [7:0]       wdata;
  logic             out_free;

  // Saturate the panel size
  always_comb begin
    if (cfg_i.width < 9'd8) begin
      bpl = BplW'(1);
    end else if ({1'b0, cfg_i.width} > 10'(MaxWidth)) begin
      bpl = BplW'(BplMax);
    end else begin
      bpl = BplW'(cfg_i.width[8:3]);
    end
    if (cfg_i.height == 9'd0) begin
      eff_h = 9'd1;
    end else if ({1'b0, cfg_i.height} > 10'(MaxHeight)) begin
      eff_h = DimW'(MaxHeight);
    end else begin
      eff_h = cfg_i.height;
    end
  end
  assign eff_w = DimW'({bpl, 3'b000});

  // Clip, then rotate into panel coordinates
  assign xs = {2'b00, x_q[8:0]};
  assign ys = {2'b00, y_q[8:0]};
  assign ws = {2'b00, eff_w};
  assign hs = {2'b00, eff_h};
  assign clip_ok = !x_q[9] && (x_q[8:0] < eff_w) && !y_q[9] && (y_q[8:0] < eff_h);

  always_comb begin
    case (cfg_i.rotation)
      2'd1: begin
        px = ws - 11'sd1 - ys;
        py = xs;
      end
      2'd2: begin
        px = ws - 11'sd1 - xs;
        py = hs - 11'sd1 - ys;
      end
      2'd3: begin
        px = ys;
        py = hs - 11'sd1 - xs;
      end
      default: begin
        px = xs;
        py = ys;
      end
    endcase
  end

  assign rot_ok    = !px[10] && (px < ws) && !py[10] && (py < hs);
  assign draw_prod = py[8:0] * bpl;
  assign draw_idx  = AddrW'(draw_prod + (DimW + BplW)'(px[8:3]));

  // Expand green to gray: g*255/63 = 4g + g/21
  always_comb begin
    if (green_q == 6'd63) begin
      gray_lo = 2'd3;
    end else if (green_q >= 6'd42) begin
      gray_lo = 2'd2;
    end else if (green_q >= 6'd21) begin
      gray_lo = 2'd1;
    end else begin
      gray_lo = 2'd0;
    end
  end
  assign gray = {green_q, 2'b00} + {6'd0, gray_lo};

  assign line_prod = y_q[8:0] * bpl;

  // Capture the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q  <= mode_e'(mode_i);
      x_q     <= pos_x_i;
      y_q     <= pos_y_i;
      green_q <= color_i[10:5];
    end
  end

  // Hold draw operands for the read-modify-write
  always_ff @(posedge clk_i) begin
    if (cmd_i.draw_calc) begin
      didx_q <= draw_idx;
      dbit_q <= px[2:0];
      dok_q  <= clip_ok && rot_ok;
      dset_q <= gray > cfg_i.threshold;
    end
  end

  // Advance the fill sweep and the line pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_start) begin
      sweep_q    <= '0;
      fill_val_q <= (mode_q == MODE_FILL_BLACK) ? FillZero : FillOnes;
    end else if (cmd_i.fill_step) begin
      sweep_q <= sweep_q + 1'b1;
    end
    if (cmd_i.line_start) begin
      lp_q  <= AddrW'(line_prod);
      cnt_q <= '0;
    end else if (cmd_i.line_next) begin
      lp_q  <= lp_q + 1'b1;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Frame store port: one write, one registered read
  assign bit_mask = 8'd1 << dbit_q;
  assign wdata    = dset_q ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_step) begin
      store_mem[sweep_q] <= fill_val_q;
    end else if (cmd_i.draw_wr) begin
      store_mem[didx_q] <= wdata;
    end
    if (cmd_i.draw_rd) begin
      rdata_q <= store_mem[didx_q];
    end else if (cmd_i.line_rd) begin
      rdata_q <= store_mem[lp_q];
    end
  end

  // Toggle VCOM after each command byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcom_q <= 1'b1;
    end else if (cmd_i.vcom_toggle) begin
      vcom_q <= !vcom_q;
    end
  end

  assign vcom_bits = vcom_q ? CmdVcom : 8'h00;

  always_comb begin
    case (cmd_i.out_sel)
      OUT_CLEAR_CMD: out_byte_d = vcom_bits | CmdClear;
      OUT_WRITE_CMD: out_byte_d = vcom_bits | CmdWrite;
      OUT_ADDR:      out_byte_d = y_q[7:0] + 8'd1;
      OUT_MEM:       out_byte_d = rdata_q;
      default:       out_byte_d = 8'h00;
    endcase
  end

  // Output word register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_byte_q <= out_byte_d;
      out_eot_q  <= cmd_i.out_eot;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_eot_o   = out_eot_q;
  assign out_last_o  = out_last_q;

  // Status to the controller
  assign sts_o.mode       = mode_q;
  assign sts_o.out_free   = out_free;
  assign sts_o.sweep_last = (sweep_q == AddrW'(StoreBytes - 1));
  assign sts_o.byte_last  = (cnt_q == bpl - 1'b1);
  assign sts_o.draw_ok    = dok_q;
  assign sts_o.line_ok    = !y_q[9] && (y_q[8:0] < eff_h);
  assign sts_o.line_final = (y_q[8:0] == eff_h - 1'b1);

endmodule

// ===== design/memory_lcd_frame_controller_core.sv =====
// Memory LCD frame controller: keeps a one-bit-per-pixel frame store and
// turns draw, fill, clear and refresh words into the panel's serial byte
// stream. Fill the store (fill white, fill black or clear screen) before the
// first refresh. A draw word steps through accept, clip/rotate/index, store
// read and store write, since each pixel is a read-modify-write of one
// byte on the single-port store. Fill and clear sweep the whole store, one
// byte a cycle, before the next word is taken, and the two clear-screen
// command bytes follow the sweep. Refresh start gives one command byte; a
// refresh line gives the address byte, each data byte by a store read, then
// an output load, and the trailer bytes, all slowed further by any
// back-pressure on the output. The output register lets the next word be
// accepted while the final byte still waits.
module memory_lcd_frame_controller_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input words
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // pos_x[9:0], pos_y[19:10], color[35:20], zero
  input  logic [2:0]  s_axis_tuser_i,  // mode[2:0]
  // Panel byte stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // out_byte[7:0]
  output logic [0:0]  m_axis_tuser_o,  // end_of_transfer[0]
  output logic        m_axis_tlast_o
);
  import mlcd_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    eot;

  mlcd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mlcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mlcd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .mode_i      (s_axis_tuser_i),
    .pos_x_i     (s_axis_tdata_i[9:0]),
    .pos_y_i     (s_axis_tdata_i[19:10]),
    .color_i     (s_axis_tdata_i[35:20]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_eot_o   (eot),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = eot;

endmodule

// ===== test/memory_lcd_frame_controller_core_tb.sv =====
module memory_lcd_frame_controller_core_tb;
  import mlcd_pkg::*;

  localparam int SettleCycles = 8300;
  localparam int LongHold     = 600;
  localparam int WordsPerPhase = 27;

  typedef struct packed {
    logic [7:0] data;
    logic       eot;
    logic       last;
  } panel_byte_t;

  // Track the frame store, VCOM and registers; hold the panel bytes still due
  class panel_stream_tracker;
    logic [7:0]  frame_mem [StoreBytes];
    bit          vcom;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [1:0]  rot_reg;
    logic [7:0]  thr_reg;
    panel_byte_t due_bytes[$];
    int          errors;
    int          bytes_seen;
    int          last_row;

    function new();
      foreach (frame_mem[i]) frame_mem[i] = 8'h00;
      vcom       = 1'b1;
      width_reg  = WidthRst;
      height_reg = HeightRst;
      rot_reg    = RotRst;
      thr_reg    = ThresholdRst;
      errors     = 0;
      bytes_seen = 0;
      last_row   = 0;
    endfunction

    // Saturate width to 8..MaxWidth and round down to whole bytes
    function int span_w();
      int w;
      w = width_reg;
      if (w < 8) w = 8;
      if (w > MaxWidth) w = MaxWidth;
      return w & ~7;
    endfunction

    function int span_h();
      int h;
      h = height_reg;
      if (h < 1) h = 1;
      if (h > MaxHeight) h = MaxHeight;
      return h;
    endfunction

    function int due_count();
      return due_bytes.size();
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] v);
      case (idx)
        REG_WIDTH:     width_reg  = v[8:0];
        REG_HEIGHT:    height_reg = v[8:0];
        REG_ROTATION:  rot_reg    = v[1:0];
        REG_THRESHOLD: thr_reg    = v[7:0];
        default: ;
      endcase
    endfunction

    function void queue_byte(logic [7:0] b, logic eot);
      panel_byte_t pb;
      pb.data = b;
      pb.eot  = eot;
      pb.last = 1'b0;
      due_bytes.push_back(pb);
    endfunction

    // Clip, rotate and update one pixel bit from the green channel
    function void plot(int x, int y, logic [15:0] color);
      int w, h, px, py, idx, g, gray;
      w = span_w();
      h = span_h();
      if (x < 0 || x >= w || y < 0 || y >= h) return;
      case (rot_reg)
        2'd1: begin px = w - 1 - y; py = x; end
        2'd2: begin px = w - 1 - x; py = h - 1 - y; end
        2'd3: begin px = y; py = h - 1 - x; end
        default: begin px = x; py = y; end
      endcase
      if (px < 0 || px >= w || py < 0 || py >= h) return;
      idx  = py * (w / 8) + px / 8;
      g    = color[10:5];
      gray = g * 255 / 63;
      if (gray > thr_reg) frame_mem[idx][px % 8] = 1'b1;
      else frame_mem[idx][px % 8] = 1'b0;
      last_row = py;
    endfunction

    // Note an accepted input word and queue the bytes it causes
    function void note_word(logic [2:0] mode, logic [9:0] xr, logic [9:0] yr,
                            logic [15:0] color);
      int x, y, h, bpl, prior_cnt;
      x         = $signed(xr);
      y         = $signed(yr);
      prior_cnt = due_bytes.size();
      case (mode)
        MODE_DRAW: plot(x, y, color);
        MODE_FILL_WHITE: foreach (frame_mem[i]) frame_mem[i] = FillOnes;
        MODE_FILL_BLACK: foreach (frame_mem[i]) frame_mem[i] = FillZero;
        MODE_CLEAR: begin
          foreach (frame_mem[i]) frame_mem[i] = FillOnes;
          queue_byte((vcom ? CmdVcom : 8'h00) | CmdClear, 1'b0);
          queue_byte(8'h00, 1'b1);
          vcom = !vcom;
        end
        MODE_REF_START: begin
          queue_byte((vcom ? CmdVcom : 8'h00) | CmdWrite, 1'b0);
          vcom = !vcom;
        end
        MODE_REF_LINE: begin
          h   = span_h();
          bpl = span_w() / 8;
          if (y >= 0 && y < h) begin
            queue_byte(8'(y + 1), 1'b0);
            for (int i = 0; i < bpl; i++) queue_byte(frame_mem[y * bpl + i], 1'b0);
            queue_byte(8'h00, 1'b0);
            if (y == h - 1) queue_byte(8'h00, 1'b1);
          end
        end
        default: ;
      endcase
      if (due_bytes.size() > prior_cnt) due_bytes[due_bytes.size() - 1].last = 1'b1;
    endfunction

    // Compare one panel byte with the oldest one due
    function void check_byte(logic [7:0] data, logic eot, logic last);
      panel_byte_t want;
      bytes_seen++;
      if (due_bytes.size() == 0) begin
        $error("unexpected panel byte %02h (eot %0b, last %0b)", data, eot, last);
        errors++;
        return;
      end
      want = due_bytes.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %02h, actual %02h", want.data, data);
        errors++;
      end
      if (eot !== want.eot) begin
        $error("end_of_transfer: expected %0b, actual %0b", want.eot, eot);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni   = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;
  bit          quiet    = 1'b0;

  panel_stream_tracker sb;

  memory_lcd_frame_controller_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("memory_lcd_frame_controller_core test failed");
    $finish;
  end

  // Sample both handshakes at the clock edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) sb.check_byte(m_tdata, m_tuser[0], m_tlast);
      if (s_tvalid && s_tready)
        sb.note_word(s_tuser, s_tdata[9:0], s_tdata[19:10], s_tdata[35:20]);
    end
  end

  // Stall the byte stream at random, with one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (!held && sb.bytes_seen >= 100) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
        repeat (quiet ? 1 : $urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // Offer one word, after an optional gap, and hold it until accepted
  task automatic send_word(input logic [2:0] mode, input int x, input int y,
                           input logic [15:0] color);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {4'b0000, color, 10'(y), 10'(x)};
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait until every due byte has come, then let a full store sweep finish
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.due_count() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int w, h, r, x, y, sent;
    logic [15:0] color;
    logic [31:0] cw, ch, cr, ct;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words on the reset geometry
    send_word(MODE_FILL_WHITE, 0, 0, 16'h0000);
    send_word(MODE_REF_START, 0, 0, 16'h0000);
    send_word(MODE_REF_LINE, 0, 0, 16'h0000);
    send_word(MODE_FILL_BLACK, 0, 0, 16'h0000);
    send_word(MODE_DRAW, 0, 0, 16'hFFFF);
    send_word(MODE_DRAW, 143, 167, 16'hFFFF);
    send_word(MODE_DRAW, 1, 0, 16'(42 << 5));
    send_word(MODE_DRAW, 2, 0, 16'(41 << 5));
    send_word(MODE_DRAW, 3, 0, 16'hFFFF);
    send_word(MODE_DRAW, 3, 0, 16'hF83F | 16'(41 << 5));
    send_word(MODE_DRAW, -1, 5, 16'hFFFF);
    send_word(MODE_DRAW, 144, 5, 16'hFFFF);
    send_word(MODE_DRAW, 5, 168, 16'hFFFF);
    send_word(MODE_DRAW, -512, -512, 16'hFFFF);
    send_word(MODE_DRAW, 511, 511, 16'hFFFF);
    send_word(MODE_REF_LINE, 0, 0, 16'h0000);
    send_word(MODE_REF_LINE, 0, 167, 16'h0000);
    send_word(MODE_REF_LINE, 0, -1, 16'h0000);
    send_word(MODE_REF_LINE, 0, 168, 16'h0000);
    send_word(MODE_REF_LINE, 0, 511, 16'h0000);
    send_word(MODE_REF_LINE, 0, -512, 16'h0000);
    send_word(MODE_CLEAR, 0, 0, 16'h0000);
    send_word(MODE_REF_START, 0, 0, 16'h0000);
    send_word(3'd6, 255, -256, 16'hA5A5);
    send_word(3'd7, -1, 300, 16'h5A5A);

    // Random phases, each on its own panel geometry
    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        cr = (p + 3) % 4;
        ct = $urandom_range(0, 255);
        case (p)
          1: begin cw = 8;   ch = 1;   ct = 0;   end
          2: begin cw = 256; ch = 256; ct = 255; end
          3: begin cw = 0;   ch = 0;   end
          4: begin cw = 511; ch = 511; end
          5: begin cw = 13;  ch = 5;   cr = 1; ct = 128; end
          6: begin cw = 40;  ch = 16;  end
          default: begin
            cw = $urandom_range(0, 511);
            ch = $urandom_range(0, 511);
            cr = $urandom_range(0, 3);
          end
        endcase
        drain();
        write_reg(REG_WIDTH, cw);
        write_reg(REG_HEIGHT, ch);
        write_reg(REG_ROTATION, cr);
        write_reg(REG_THRESHOLD, ct);
        if (p == 7) quiet = 1'b1;
      end
      sent = 0;
      while (sent < WordsPerPhase) begin
        w     = sb.span_w();
        h     = sb.span_h();
        r     = $urandom_range(0, 99);
        color = 16'($urandom());
        sent++;
        if (r < 38) begin
          send_word(MODE_DRAW, $urandom_range(0, w - 1), $urandom_range(0, h - 1), color);
        end else if (r < 45) begin
          x = $urandom_range(0, 1023);
          y = $urandom_range(0, 1023);
          send_word(MODE_DRAW, x - 512, y - 512, color);
        end else if (r < 70) begin
          y = $urandom_range(0, 1) ? sb.last_row % h : $urandom_range(0, h - 1);
          send_word(MODE_REF_LINE, $urandom_range(0, 1023), y, color);
        end else if (r < 75) begin
          y = $urandom_range(0, 1023);
          send_word(MODE_REF_LINE, 0, y - 512, color);
        end else if (r < 90) begin
          send_word(MODE_REF_START, 0, 0, color);
        end else if (r < 91) begin
          send_word(MODE_FILL_WHITE, 0, 0, color);
        end else if (r < 92) begin
          send_word(MODE_FILL_BLACK, 0, 0, color);
        end else if (r < 94) begin
          send_word(MODE_CLEAR, 0, 0, color);
        end else begin
          // unused modes are ignored, so they do not count
          sent--;
          send_word(3'($urandom_range(6, 7)), $urandom_range(0, 1023),
                    $urandom_range(0, 1023), color);
        end
      end
    end

    drain();
    if (sb.errors == 0 && sb.due_count() == 0) begin
      $display("memory_lcd_frame_controller_core test passed");
    end else begin
      $display("memory_lcd_frame_controller_core test failed");
    end
    $finish;
  end

endmodule
